>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the UTF-8 stream decoder.
// Depends on nothing; files that assert take this header by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/u8d_pkg.sv
// Types and constants of the UTF-8 stream decoder.
// Depends on nothing; used by utf8_stream_decoder.
package u8d_pkg;

   localparam int unsigned CpWidth = 21;

   localparam logic [7:0] ContMask   = 8'hC0;
   localparam logic [7:0] ContCode   = 8'h80;
   localparam logic [7:0] PayloadMask = 8'h3F;
   localparam logic [7:0] Lead3Min   = 8'hE0;
   localparam logic [7:0] Lead4Min   = 8'hF0;
   localparam logic [7:0] InvalidMin = 8'hF8;

   localparam logic [CpWidth-1:0] SurrLo = 21'h00D800;
   localparam logic [CpWidth-1:0] SurrHi = 21'h00DFFF;

   typedef struct packed {
      logic [CpWidth-1:0] code_point;
      logic               is_error;
      logic               last_of_run;
   } result_type;

endpackage

>>> rtl/utf8_stream_decoder.sv
// UTF-8 stream decoder: input byte register, decode logic and a two-entry result buffer.
// Depends on u8d_pkg and assert_macros.svh.
//
// Usage:
//  Bytes enter on the req_ channel, one per transfer, with req_end_of_data marking the
//  final byte of a text. Each byte gives zero, one or two results on the rsp_ channel:
//  a decoded code point or an error mark (code point zero). rsp_last_of_run is set on
//  the final result that a byte causes; a byte that gives no result shows nothing.
//  A byte is taken into an input register and decoded from there; when it advances, its
//  results enter the result buffer and the first result is shown on the rsp_ channel.
//  One byte per cycle is sustained while rsp_stall is low; a byte that gives two results
//  holds the input register while the second result is sent,
//  as the result buffer has one output port.
//  While rsp_stall is high the results wait in the buffer and one further byte waits
//  in the input register, after which req_stall is raised.
//  A byte with end_of_data reports any unfinished sequence as an error and returns the
//  decoder to its reset state. Synchronous reset empties both registers and clears the
//  pending sequence and the stray-skipping flag.
module utf8_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [20:0] rsp_code_point,
   output logic        rsp_is_error,
   output logic        rsp_last_of_run
);

`include "assert_macros.svh"

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_eod_ff, in_eod_in;

   // Decoder state.
   logic [20:0] acc_ff, acc_in;
   logic [1:0]  rem_ff, rem_in;
   logic        skip_ff, skip_in;

   // Result buffer.
   u8d_pkg::result_type slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic                slot0_valid_ff, slot0_valid_in, slot1_valid_ff, slot1_valid_in;

   logic advance, drain0, req_take;

   // Decode signals.
   logic [7:0]  b;
   logic        cont;
   logic        run_start;
   logic        sb_res, sb_err, sb_skip;
   logic [20:0] sb_cp, sb_acc;
   logic [1:0]  sb_rem;
   logic        ev_a, ev_a_err, ev_b, ev_c;
   logic [20:0] ev_a_cp, acc_shift, acc_mid;
   logic [1:0]  rem_dec, rem_mid;
   logic        skip_mid, surr;
   u8d_pkg::result_type r0, r1;
   logic        r0_valid, r1_valid;

   assign drain0    = slot0_valid_ff && !rsp_stall;
   assign advance   = in_valid_ff && !slot1_valid_ff && (!slot0_valid_ff || drain0);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid       = slot0_valid_ff;
   assign rsp_code_point  = slot0_ff.code_point;
   assign rsp_is_error    = slot0_ff.is_error;
   assign rsp_last_of_run = slot0_ff.last_of_run;

   // Decoding of a byte taken as a fresh start: no sequence pending, a broken sequence or a skip that ends.
   always_comb begin
      b       = in_byte_ff;
      cont    = (b & u8d_pkg::ContMask) == u8d_pkg::ContCode;
      sb_res  = 1'b0;
      sb_err  = 1'b0;
      sb_skip = 1'b0;
      sb_cp   = '0;
      sb_acc  = '0;
      sb_rem  = 2'd0;
      if (!b[7]) begin
         sb_res = 1'b1;
         sb_cp  = {13'd0, b};
      end else if (cont || b >= u8d_pkg::InvalidMin) begin
         sb_res  = 1'b1;
         sb_err  = 1'b1;
         sb_skip = 1'b1;
      end else if (b < u8d_pkg::Lead3Min) begin
         sb_acc = {16'd0, b[4:0]};
         sb_rem = 2'd1;
      end else if (b < u8d_pkg::Lead4Min) begin
         sb_acc = {17'd0, b[3:0]};
         sb_rem = 2'd2;
      end else begin
         sb_acc = {18'd0, b[2:0]};
         sb_rem = 2'd3;
      end
   end

   // Main step: event a comes from the pending sequence, event b from a new start
   // byte and event c from truncation at end of data. At most two of them fire.
   always_comb begin
      acc_shift = {acc_ff[14:0], b[5:0]};
      rem_dec   = rem_ff - 2'd1;
      surr      = (acc_shift >= u8d_pkg::SurrLo) && (acc_shift <= u8d_pkg::SurrHi);
      ev_a      = 1'b0;
      ev_a_err  = 1'b0;
      ev_a_cp   = '0;
      run_start = 1'b0;
      acc_mid   = acc_ff;
      rem_mid   = rem_ff;
      skip_mid  = skip_ff;
      if (rem_ff != 2'd0) begin
         if (cont) begin
            rem_mid = rem_dec;
            if (rem_dec == 2'd0) begin
               ev_a     = 1'b1;
               ev_a_err = surr;
               ev_a_cp  = surr ? '0 : acc_shift;
               acc_mid  = '0;
            end else begin
               acc_mid = acc_shift;
            end
         end else begin
            // A broken sequence is reported, then the byte is taken as a fresh start.
            ev_a      = 1'b1;
            ev_a_err  = 1'b1;
            run_start = 1'b1;
         end
      end else if (skip_ff) begin
         if (!cont) begin
            skip_mid  = 1'b0;
            run_start = 1'b1;
         end
      end else begin
         run_start = 1'b1;
      end

      ev_b = run_start && sb_res;
      if (run_start) begin
         acc_mid = sb_acc;
         rem_mid = sb_rem;
         if (sb_skip) begin
            skip_mid = 1'b1;
         end
      end

      ev_c = in_eod_ff && (rem_mid != 2'd0);
      if (in_eod_ff) begin
         acc_in  = '0;
         rem_in  = 2'd0;
         skip_in = 1'b0;
      end else begin
         acc_in  = acc_mid;
         rem_in  = rem_mid;
         skip_in = skip_mid;
      end

      r0       = '0;
      r1       = '0;
      r0_valid = 1'b0;
      r1_valid = 1'b0;
      if (ev_a) begin
         r0_valid      = 1'b1;
         r0.code_point = ev_a_cp;
         r0.is_error   = ev_a_err;
         r1_valid      = ev_b || ev_c;
         r1.code_point = ev_b ? sb_cp : '0;
         r1.is_error   = ev_b ? sb_err : 1'b1;
      end else if (ev_b) begin
         r0_valid      = 1'b1;
         r0.code_point = sb_cp;
         r0.is_error   = sb_err;
         r1_valid      = ev_c;
         r1.is_error   = 1'b1;
      end else begin
         r0_valid    = ev_c;
         r0.is_error = 1'b1;
      end
      r0.last_of_run = !r1_valid;
      r1.last_of_run = 1'b1;
   end

   // Input register and result buffer next values.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_eod_in   = in_eod_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_data_byte;
         in_eod_in   = req_end_of_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      slot0_in       = slot0_ff;
      slot1_in       = slot1_ff;
      slot0_valid_in = slot0_valid_ff;
      slot1_valid_in = slot1_valid_ff;
      if (advance) begin
         slot0_in       = r0;
         slot1_in       = r1;
         slot0_valid_in = r0_valid;
         slot1_valid_in = r1_valid;
      end else if (drain0) begin
         slot0_in       = slot1_ff;
         slot0_valid_in = slot1_valid_ff;
         slot1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         slot0_valid_ff <= 1'b0;
         slot1_valid_ff <= 1'b0;
         acc_ff         <= '0;
         rem_ff         <= 2'd0;
         skip_ff        <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         slot0_valid_ff <= slot0_valid_in;
         slot1_valid_ff <= slot1_valid_in;
         if (advance) begin
            acc_ff  <= acc_in;
            rem_ff  <= rem_in;
            skip_ff <= skip_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_eod_ff  <= in_eod_in;
      slot0_ff   <= slot0_in;
      slot1_ff   <= slot1_in;
   end

   `ASSERT_IMPLIES(a_slot_order, clock, reset, slot1_valid_ff, slot0_valid_ff,
                   "second result without first")
   `ASSERT_IMPLIES(a_pending_no_skip, clock, reset, rem_ff != 2'd0, !skip_ff,
                   "skipping while sequence pending")
   `ASSERT_IMPLIES(a_error_zero, clock, reset, slot0_valid_ff && slot0_ff.is_error,
                   slot0_ff.code_point == '0, "error result with nonzero code point")
   `ASSERT_NEXT(a_eod_clears, clock, reset, advance && in_eod_ff,
                rem_ff == 2'd0 && !skip_ff && acc_ff == '0,
                "state not cleared after end of data")

endmodule
